/* rtl/apmd_pkg.sv */
// ============================================================================
// apmd_pkg: shared types and constants of the averaging panel meter display
// Sizes, calibration constants, reciprocal multipliers, payload structs and
// the digit split function used by the formatting stage.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package apmd_pkg;

   // Window and sample sizing
   localparam int WINDOW      = 16;
   localparam int SAMPLE_BITS = 12;
   localparam int SLOT_BITS   = $clog2(WINDOW);
   localparam int TOTAL_BITS  = SAMPLE_BITS + SLOT_BITS;

   // Register stages between an accepted sample pair and its result
   localparam int PIPE_DEPTH = 6;

   // Fixed field widths
   localparam int RAW_BITS      = 12;
   localparam int VOLT_BITS     = 11;
   localparam int AMP_BITS      = 12;
   localparam int CSR_DATA_BITS = 12;
   localparam int NUM_BITS      = 10;

   // Mean: total / WINDOW as an exact reciprocal multiply
   localparam int              MEAN_SHIFT    = TOTAL_BITS + SLOT_BITS;
   localparam int              MEAN_MUL_BITS = 2 * TOTAL_BITS + 1;
   localparam longint unsigned MEAN_RECIP    =
      ((64'd1 << MEAN_SHIFT) + WINDOW - 1) / WINDOW;

   // Voltage calibration: mean * 12200 / 48977
   localparam int              VOLT_NUM        = 12200;
   localparam int              VOLT_DEN        = 48977;
   localparam int              VOLT_PROD_BITS  = SAMPLE_BITS + 14;
   localparam int              VOLT_SHIFT      = VOLT_PROD_BITS + 16;
   localparam int              VOLT_RECIP_BITS = VOLT_SHIFT - 15;
   localparam int              VOLT_QMUL_BITS  = VOLT_PROD_BITS + VOLT_RECIP_BITS;
   localparam longint unsigned VOLT_RECIP      =
      ((64'd1 << VOLT_SHIFT) + VOLT_DEN - 1) / VOLT_DEN;
   localparam int              VOLT_MAX        = 2047;

   // Current calibration, two segments around the knee
   localparam int AMP_KNEE   = 1014;
   localparam int AMP_LO_OFS = 83;
   localparam int AMP_LO_NUM = 1634000;
   localparam int AMP_LO_DEN = 2518955;
   localparam int AMP_HI_OFS = 62;
   localparam int AMP_HI_NUM = 86000;
   localparam int AMP_HI_DEN = 135423;
   localparam int AMP_MAX    = 4095;

   localparam int AMP_COEF_BITS   = 21;
   localparam int AMP_MUL0_BITS   = SAMPLE_BITS + AMP_COEF_BITS;
   localparam int AMP_PROD_BITS   = (SAMPLE_BITS + 17 > 31) ? SAMPLE_BITS + 17 : 31;
   localparam int AMP_LO_SHIFT    = 31 + 22;
   localparam int AMP_HI_SHIFT    = SAMPLE_BITS + 17 + 18;
   localparam int AMP_RECIP_BITS  = (SAMPLE_BITS + 18 > 32) ? SAMPLE_BITS + 18 : 32;
   localparam int AMP_QMUL_BITS   = AMP_PROD_BITS + AMP_RECIP_BITS;
   localparam longint unsigned AMP_LO_RECIP =
      ((64'd1 << AMP_LO_SHIFT) + AMP_LO_DEN - 1) / AMP_LO_DEN;
   localparam longint unsigned AMP_HI_RECIP =
      ((64'd1 << AMP_HI_SHIFT) + AMP_HI_DEN - 1) / AMP_HI_DEN;

   // Divide by ten for values below 2^12
   localparam int DIV10_RECIP = 52429;
   localparam int DIV10_SHIFT = 19;
   localparam int DIV10_BITS  = AMP_BITS + 16;

   // Display symbol codes
   typedef logic [3:0] sym_type;
   localparam sym_type SYM_BLANK = 4'd10;
   localparam sym_type SYM_L     = 4'd11;
   localparam sym_type SYM_O     = 4'd12;
   localparam sym_type SYM_V     = 4'd13;

   // Register indexes
   typedef enum logic [1:0] {
      CSR_VOLT_LOW   = 2'd0,
      CSR_VOLT_HIGH  = 2'd1,
      CSR_VOLT_SPLIT = 2'd2,
      CSR_AMP_SPLIT  = 2'd3
   } csr_index_type;

   // Voltage display mode
   typedef enum logic [1:0] {
      VMODE_BLANK,
      VMODE_LOW,
      VMODE_OVER,
      VMODE_NUM
   } vmode_type;

   typedef struct packed {
      logic [RAW_BITS-1:0] volt_sample;
      logic [RAW_BITS-1:0] amp_sample;
   } req_type;

   typedef struct packed {
      logic [VOLT_BITS-1:0] volts_scaled;
      logic [AMP_BITS-1:0]  amps_scaled;
      sym_type              volt_sym_first;
      sym_type              volt_sym_second;
      sym_type              volt_sym_third;
      logic                 volt_point;
      sym_type              amp_sym_first;
      sym_type              amp_sym_second;
      sym_type              amp_sym_third;
      logic                 amp_point;
      logic                 shown;
   } rsp_type;

   typedef struct packed {
      logic [VOLT_BITS-1:0] volt_low_limit;
      logic [VOLT_BITS-1:0] volt_high_limit;
      logic [VOLT_BITS-1:0] volt_range_split;
      logic [AMP_BITS-1:0]  amp_range_split;
   } cfg_type;

   typedef struct packed {
      logic [TOTAL_BITS-1:0] volt_total;
      logic [TOTAL_BITS-1:0] amp_total;
      logic                  full;
   } total_type;

   typedef struct packed {
      logic [VOLT_BITS-1:0] volts;
      logic [AMP_BITS-1:0]  amps;
      logic                 full;
   } scaled_type;

   typedef struct packed {
      logic [VOLT_BITS-1:0] volts;
      logic [AMP_BITS-1:0]  amps;
      logic                 full;
      vmode_type            vmode;
      logic [NUM_BITS-1:0]  vnum;
      logic                 vpoint;
      logic [NUM_BITS-1:0]  anum;
      logic                 ablank;
      logic                 apoint;
   } disp_type;

   typedef struct packed {
      sym_type first;
      sym_type second;
      sym_type third;
   } sym3_type;

   // Limit a displayed number to 999
   function automatic logic [NUM_BITS-1:0] clamp999(input logic [AMP_BITS-1:0] n);
      return (n > 12'd999) ? 10'd999 : n[NUM_BITS-1:0];
   endfunction

   // Split 0..999 into hundreds, tens, ones; optional leading zero blanking
   function automatic sym3_type digits3(input logic [NUM_BITS-1:0] n,
                                        input logic blank_lead);
      sym3_type            d;
      logic [3:0]          h;
      logic [3:0]          t;
      logic [NUM_BITS-1:0] rest;
      logic [6:0]          r2;
      h = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (n >= 10'(k * 100)) h = 4'(k);
      end
      rest = n - (10'(h) * 10'd100);
      r2   = rest[6:0];
      t = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (r2 >= 7'(k * 10)) t = 4'(k);
      end
      d.third = 4'(r2 - (7'(t) * 7'd10));
      if ((h == 4'd0) && blank_lead) begin
         d.first  = SYM_BLANK;
         d.second = (t == 4'd0) ? SYM_BLANK : t;
      end else begin
         d.first  = h;
         d.second = t;
      end
      return d;
   endfunction

endpackage

`default_nettype wire

/* rtl/apmd_csr.sv */
// ============================================================================
// apmd_csr: display limit registers
// Four write-only limits for the voltage and current display.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module apmd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  apmd_pkg::csr_index_type              csr_index,
   input  logic [apmd_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output apmd_pkg::cfg_type                    cfg
);
   import apmd_pkg::*;

   cfg_type cfg_ff;

   // Register writes, one index per transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.volt_low_limit   <= 11'd300;
         cfg_ff.volt_high_limit  <= 11'd2047;
         cfg_ff.volt_range_split <= 11'd1000;
         cfg_ff.amp_range_split  <= 12'd1000;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_VOLT_LOW:   cfg_ff.volt_low_limit   <= csr_wdata[VOLT_BITS-1:0];
            CSR_VOLT_HIGH:  cfg_ff.volt_high_limit  <= csr_wdata[VOLT_BITS-1:0];
            CSR_VOLT_SPLIT: cfg_ff.volt_range_split <= csr_wdata[VOLT_BITS-1:0];
            CSR_AMP_SPLIT:  cfg_ff.amp_range_split  <= csr_wdata[AMP_BITS-1:0];
            default:        cfg_ff <= cfg_ff;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/apmd_window.sv */
// ============================================================================
// apmd_window: sample rings and running window sums
// Stores each sample pair, keeps the ring totals current and hands a
// snapshot of both totals downstream.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module apmd_window (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  apmd_pkg::req_type    req_data,
   output logic                 tot_valid,
   input  logic                 tot_ready,
   output apmd_pkg::total_type  tot_data
);
   import apmd_pkg::*;

   logic [SAMPLE_BITS-1:0] volt_ring_ff [WINDOW];
   logic [SAMPLE_BITS-1:0] amp_ring_ff  [WINDOW];
   logic [SLOT_BITS-1:0]   slot_ff;
   logic [SLOT_BITS-1:0]   slot_in;
   logic                   full_ff;
   logic                   full_in;
   logic [TOTAL_BITS-1:0]  volt_total_ff;
   logic [TOTAL_BITS-1:0]  volt_total_in;
   logic [TOTAL_BITS-1:0]  amp_total_ff;
   logic [TOTAL_BITS-1:0]  amp_total_in;
   logic [SAMPLE_BITS-1:0] volt_new;
   logic [SAMPLE_BITS-1:0] amp_new;
   logic                   last_slot;
   logic                   ready;
   logic                   accept;
   logic                   tot_valid_ff;
   total_type              tot_ff;

   assign ready     = !tot_valid_ff || tot_ready;
   assign req_stall = !ready;
   assign accept    = req_valid && ready;

   assign volt_new = SAMPLE_BITS'(req_data.volt_sample);
   assign amp_new  = SAMPLE_BITS'(req_data.amp_sample);

   // Running sums: drop the oldest sample, add the new one
   assign volt_total_in = volt_total_ff - TOTAL_BITS'(volt_ring_ff[slot_ff])
                          + TOTAL_BITS'(volt_new);
   assign amp_total_in  = amp_total_ff - TOTAL_BITS'(amp_ring_ff[slot_ff])
                          + TOTAL_BITS'(amp_new);

   assign last_slot = (slot_ff == SLOT_BITS'(WINDOW - 1));
   assign slot_in   = last_slot ? '0 : slot_ff + 1'b1;
   assign full_in   = full_ff || last_slot;

   // Ring state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW; i++) begin
            volt_ring_ff[i] <= '0;
            amp_ring_ff[i]  <= '0;
         end
         slot_ff       <= '0;
         full_ff       <= 1'b0;
         volt_total_ff <= '0;
         amp_total_ff  <= '0;
      end else if (accept) begin
         volt_ring_ff[slot_ff] <= volt_new;
         amp_ring_ff[slot_ff]  <= amp_new;
         slot_ff               <= slot_in;
         full_ff               <= full_in;
         volt_total_ff         <= volt_total_in;
         amp_total_ff          <= amp_total_in;
      end
   end

   // Snapshot stage
   always_ff @(posedge clock) begin
      if (reset) begin
         tot_valid_ff <= 1'b0;
      end else if (ready) begin
         tot_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         tot_ff.volt_total <= volt_total_in;
         tot_ff.amp_total  <= amp_total_in;
         tot_ff.full       <= full_in;
      end
   end

   assign tot_valid = tot_valid_ff;
   assign tot_data  = tot_ff;

endmodule

`default_nettype wire

/* rtl/apmd_scale.sv */
// ============================================================================
// apmd_scale: window means and calibration
// Three stages: mean by reciprocal, calibration product, division by the
// calibration denominator through an exact reciprocal, with clamping.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module apmd_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tot_valid,
   output logic                  tot_ready,
   input  apmd_pkg::total_type   tot_data,
   output logic                  sc_valid,
   input  logic                  sc_ready,
   output apmd_pkg::scaled_type  sc_data
);
   import apmd_pkg::*;

   // Stage handshake
   logic m_valid_ff;
   logic p_valid_ff;
   logic q_valid_ff;
   logic m_ready;
   logic p_ready;
   logic q_ready;

   // Mean stage
   logic [MEAN_MUL_BITS-1:0] volt_mean_mul;
   logic [MEAN_MUL_BITS-1:0] amp_mean_mul;
   logic [SAMPLE_BITS-1:0]   volt_mean_ff;
   logic [SAMPLE_BITS-1:0]   amp_mean_ff;
   logic                     m_full_ff;

   // Product stage
   logic [VOLT_PROD_BITS-1:0] volt_prod_in;
   logic [VOLT_PROD_BITS-1:0] volt_prod_ff;
   logic                      amp_zero_in;
   logic                      amp_zero_ff;
   logic                      amp_high_in;
   logic                      amp_high_ff;
   logic [SAMPLE_BITS-1:0]    amp_diff;
   logic [AMP_COEF_BITS-1:0]  amp_coef;
   logic [AMP_MUL0_BITS-1:0]  amp_mul0;
   logic [AMP_PROD_BITS-1:0]  amp_prod_ff;
   logic                      p_full_ff;

   // Quotient stage
   logic [VOLT_QMUL_BITS-1:0] volt_qmul;
   logic [VOLT_QMUL_BITS-1:0] volt_quot;
   logic [AMP_RECIP_BITS-1:0] amp_recip;
   logic [AMP_QMUL_BITS-1:0]  amp_qmul;
   logic [AMP_QMUL_BITS-1:0]  amp_quot;
   logic [VOLT_BITS-1:0]      volts_in;
   logic [AMP_BITS-1:0]       amps_in;
   scaled_type                q_ff;

   assign q_ready   = !q_valid_ff || sc_ready;
   assign p_ready   = !p_valid_ff || q_ready;
   assign m_ready   = !m_valid_ff || p_ready;
   assign tot_ready = m_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         p_valid_ff <= 1'b0;
         q_valid_ff <= 1'b0;
      end else begin
         if (m_ready) m_valid_ff <= tot_valid;
         if (p_ready) p_valid_ff <= m_valid_ff;
         if (q_ready) q_valid_ff <= p_valid_ff;
      end
   end

   // Mean: total / WINDOW
   assign volt_mean_mul = MEAN_MUL_BITS'(tot_data.volt_total) * MEAN_MUL_BITS'(MEAN_RECIP);
   assign amp_mean_mul  = MEAN_MUL_BITS'(tot_data.amp_total) * MEAN_MUL_BITS'(MEAN_RECIP);

   always_ff @(posedge clock) begin
      if (m_ready && tot_valid) begin
         volt_mean_ff <= SAMPLE_BITS'(volt_mean_mul >> MEAN_SHIFT);
         amp_mean_ff  <= SAMPLE_BITS'(amp_mean_mul >> MEAN_SHIFT);
         m_full_ff    <= tot_data.full;
      end
   end

   // Calibration products; current picks its segment
   assign volt_prod_in = VOLT_PROD_BITS'(volt_mean_ff) * VOLT_PROD_BITS'(VOLT_NUM);
   assign amp_zero_in  = 32'(amp_mean_ff) < 32'(AMP_LO_OFS);
   assign amp_high_in  = 32'(amp_mean_ff) >= 32'(AMP_KNEE);
   assign amp_diff     = amp_high_in ? amp_mean_ff - SAMPLE_BITS'(AMP_HI_OFS)
                                     : amp_mean_ff - SAMPLE_BITS'(AMP_LO_OFS);
   assign amp_coef     = amp_high_in ? AMP_COEF_BITS'(AMP_HI_NUM)
                                     : AMP_COEF_BITS'(AMP_LO_NUM);
   assign amp_mul0     = AMP_MUL0_BITS'(amp_diff) * AMP_MUL0_BITS'(amp_coef);

   always_ff @(posedge clock) begin
      if (p_ready && m_valid_ff) begin
         volt_prod_ff <= volt_prod_in;
         amp_prod_ff  <= AMP_PROD_BITS'(amp_mul0);
         amp_zero_ff  <= amp_zero_in;
         amp_high_ff  <= amp_high_in;
         p_full_ff    <= m_full_ff;
      end
   end

   // Division by reciprocal, then clamp to field range
   assign volt_qmul = VOLT_QMUL_BITS'(volt_prod_ff) * VOLT_QMUL_BITS'(VOLT_RECIP);
   assign volt_quot = volt_qmul >> VOLT_SHIFT;
   assign volts_in  = (volt_quot > VOLT_QMUL_BITS'(VOLT_MAX)) ? VOLT_BITS'(VOLT_MAX)
                                                              : VOLT_BITS'(volt_quot);

   assign amp_recip = amp_high_ff ? AMP_RECIP_BITS'(AMP_HI_RECIP)
                                  : AMP_RECIP_BITS'(AMP_LO_RECIP);
   assign amp_qmul  = AMP_QMUL_BITS'(amp_prod_ff) * AMP_QMUL_BITS'(amp_recip);
   assign amp_quot  = amp_high_ff ? (amp_qmul >> AMP_HI_SHIFT) : (amp_qmul >> AMP_LO_SHIFT);

   always_comb begin
      if (amp_zero_ff) begin
         amps_in = '0;
      end else if (amp_quot > AMP_QMUL_BITS'(AMP_MAX)) begin
         amps_in = AMP_BITS'(AMP_MAX);
      end else begin
         amps_in = AMP_BITS'(amp_quot);
      end
   end

   always_ff @(posedge clock) begin
      if (q_ready && p_valid_ff) begin
         q_ff.volts <= volts_in;
         q_ff.amps  <= amps_in;
         q_ff.full  <= p_full_ff;
      end
   end

   assign sc_valid = q_valid_ff;
   assign sc_data  = q_ff;

endmodule

`default_nettype wire

/* rtl/apmd_format.sv */
// ============================================================================
// apmd_format: display symbol generation
// Chooses the display range and mode, then splits the number into digits
// and holds the finished result in the output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module apmd_format (
   input  logic                  clock,
   input  logic                  reset,
   input  apmd_pkg::cfg_type     cfg,
   input  logic                  sc_valid,
   output logic                  sc_ready,
   input  apmd_pkg::scaled_type  sc_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output apmd_pkg::rsp_type     rsp_data
);
   import apmd_pkg::*;

   logic                  s_valid_ff;
   logic                  s_ready;
   logic                  r_ready;
   logic                  rsp_valid_ff;
   logic [DIV10_BITS-1:0] v10_mul;
   logic [DIV10_BITS-1:0] a10_mul;
   logic [AMP_BITS-1:0]   v10;
   logic [AMP_BITS-1:0]   a10;
   logic                  v_upper;
   disp_type              disp_in;
   disp_type              disp_ff;
   sym3_type              vdig;
   sym3_type              adig;
   rsp_type               rsp_in;
   rsp_type               rsp_ff;

   assign r_ready  = !rsp_valid_ff || !rsp_stall;
   assign s_ready  = !s_valid_ff || r_ready;
   assign sc_ready = s_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s_ready) s_valid_ff <= sc_valid;
         if (r_ready) rsp_valid_ff <= s_valid_ff;
      end
   end

   // Tenths of each value
   assign v10_mul = DIV10_BITS'(sc_data.volts) * DIV10_BITS'(DIV10_RECIP);
   assign a10_mul = DIV10_BITS'(sc_data.amps) * DIV10_BITS'(DIV10_RECIP);
   assign v10     = AMP_BITS'(v10_mul >> DIV10_SHIFT);
   assign a10     = AMP_BITS'(a10_mul >> DIV10_SHIFT);
   assign v_upper = sc_data.volts >= cfg.volt_range_split;

   // Range and mode selection
   always_comb begin
      disp_in.volts = sc_data.volts;
      disp_in.amps  = sc_data.amps;
      disp_in.full  = sc_data.full;
      priority if (!sc_data.full) begin
         disp_in.vmode = VMODE_BLANK;
      end else if (sc_data.volts < cfg.volt_low_limit) begin
         disp_in.vmode = VMODE_LOW;
      end else if (sc_data.volts >= cfg.volt_high_limit) begin
         disp_in.vmode = VMODE_OVER;
      end else begin
         disp_in.vmode = VMODE_NUM;
      end
      disp_in.vnum   = v_upper ? clamp999(v10) : clamp999(AMP_BITS'(sc_data.volts));
      disp_in.vpoint = !v_upper;
      if (sc_data.amps < cfg.amp_range_split) begin
         disp_in.anum   = clamp999(sc_data.amps);
         disp_in.ablank = 1'b1;
         disp_in.apoint = 1'b0;
      end else begin
         disp_in.anum   = clamp999(a10);
         disp_in.ablank = 1'b0;
         disp_in.apoint = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (s_ready && sc_valid) begin
         disp_ff <= disp_in;
      end
   end

   // Digit split and symbol assembly
   assign vdig = digits3(disp_ff.vnum, 1'b0);
   assign adig = digits3(disp_ff.anum, disp_ff.ablank);

   always_comb begin
      rsp_in.volts_scaled = disp_ff.volts;
      rsp_in.amps_scaled  = disp_ff.amps;
      rsp_in.shown        = disp_ff.full;
      unique case (disp_ff.vmode)
         VMODE_BLANK: begin
            rsp_in.volt_sym_first  = SYM_BLANK;
            rsp_in.volt_sym_second = SYM_BLANK;
            rsp_in.volt_sym_third  = SYM_BLANK;
            rsp_in.volt_point      = 1'b0;
         end
         VMODE_LOW: begin
            rsp_in.volt_sym_first  = SYM_BLANK;
            rsp_in.volt_sym_second = SYM_L;
            rsp_in.volt_sym_third  = SYM_O;
            rsp_in.volt_point      = 1'b0;
         end
         VMODE_OVER: begin
            rsp_in.volt_sym_first  = SYM_BLANK;
            rsp_in.volt_sym_second = SYM_O;
            rsp_in.volt_sym_third  = SYM_V;
            rsp_in.volt_point      = 1'b0;
         end
         VMODE_NUM: begin
            rsp_in.volt_sym_first  = vdig.first;
            rsp_in.volt_sym_second = vdig.second;
            rsp_in.volt_sym_third  = vdig.third;
            rsp_in.volt_point      = disp_ff.vpoint;
         end
         default: begin
            rsp_in.volt_sym_first  = SYM_BLANK;
            rsp_in.volt_sym_second = SYM_BLANK;
            rsp_in.volt_sym_third  = SYM_BLANK;
            rsp_in.volt_point      = 1'b0;
         end
      endcase
      if (disp_ff.full) begin
         rsp_in.amp_sym_first  = adig.first;
         rsp_in.amp_sym_second = adig.second;
         rsp_in.amp_sym_third  = adig.third;
         rsp_in.amp_point      = disp_ff.apoint;
      end else begin
         rsp_in.amp_sym_first  = SYM_BLANK;
         rsp_in.amp_sym_second = SYM_BLANK;
         rsp_in.amp_sym_third  = SYM_BLANK;
         rsp_in.amp_point      = 1'b0;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (r_ready && s_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

/* rtl/averaging_panel_meter_display.sv */
// Throughput: one sample pair per cycle unless the result side stalls; six register stages
//   (window snapshot, mean, calibration product, reciprocal divide, range select, output),
//   each loads when free; a result is presented once its pair has passed them all.
// A stalled result stage backs up into the pipe; bubbles are squeezed out.
// Reset (synchronous): rings, sums, slot and window-full flag clear; limits return
//   to 300 / 2047 / 1000 / 1000; no result is valid.
// ============================================================================
// averaging_panel_meter_display: averaging voltage / current panel meter
// Moving window average of both ADC channels, calibration and display
// symbol generation.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module averaging_panel_meter_display (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  apmd_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output apmd_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_en,
   input  apmd_pkg::csr_index_type             csr_index,
   input  logic [apmd_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import apmd_pkg::*;

   cfg_type    cfg;
   logic       tot_valid;
   logic       tot_ready;
   total_type  tot_data;
   logic       sc_valid;
   logic       sc_ready;
   scaled_type sc_data;

   apmd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   apmd_window u_window (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .tot_valid (tot_valid),
      .tot_ready (tot_ready),
      .tot_data  (tot_data)
   );

   apmd_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .tot_valid (tot_valid),
      .tot_ready (tot_ready),
      .tot_data  (tot_data),
      .sc_valid  (sc_valid),
      .sc_ready  (sc_ready),
      .sc_data   (sc_data)
   );

   apmd_format u_format (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .sc_valid  (sc_valid),
      .sc_ready  (sc_ready),
      .sc_data   (sc_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

/* rtl/apmd_checker.sv */
// ============================================================================
// apmd_checker: port level checks for the panel meter display
// Tracks transfers on both channels and checks result ordering rules.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module apmd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input apmd_pkg::rsp_type  rsp_data
);
   import apmd_pkg::*;

   logic       req_xfer;
   logic       rsp_xfer;
   logic [3:0] pending_ff;
   logic [3:0] pending_in;
   logic       seen_full_ff;
   logic       seen_full_in;

   assign req_xfer     = req_valid && !req_stall;
   assign rsp_xfer     = rsp_valid && !rsp_stall;
   assign pending_in   = pending_ff + 4'(req_xfer) - 4'(rsp_xfer);
   assign seen_full_in = seen_full_ff || (rsp_xfer && rsp_data.shown);

   // Outstanding items and sticky window-full tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= '0;
         seen_full_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         seen_full_ff <= seen_full_in;
      end
   end

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // No result without an accepted sample pair
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 4'd0)
      else $error("result without accepted input");

   // Never more items in flight than pipeline stages
   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= 4'(PIPE_DEPTH))
      else $error("too many items in flight");

   // Before the window fills, all symbols blank and points dark
   a_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.shown |->
         rsp_data.volt_sym_first == SYM_BLANK && rsp_data.volt_sym_second == SYM_BLANK &&
         rsp_data.volt_sym_third == SYM_BLANK && rsp_data.amp_sym_first == SYM_BLANK &&
         rsp_data.amp_sym_second == SYM_BLANK && rsp_data.amp_sym_third == SYM_BLANK &&
         !rsp_data.volt_point && !rsp_data.amp_point)
      else $error("symbols shown before window full");

   // Once shown, stays shown until reset
   a_shown_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_full_ff |-> rsp_data.shown)
      else $error("shown dropped after window filled");

endmodule

bind averaging_panel_meter_display apmd_checker u_apmd_checker (.*);

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for averaging_panel_meter_display
// Feeds voltage / current sample pairs through the moving-average meter and
// checks every displayed reading against an in-bench model of the window
// sums, calibration and symbol formatting (two directed rows use fixed values).
// A short directed table comes first, then bursts of level-plus-jitter samples
// under several register settings, with random idle cycles on both channels.
// ============================================================================

module tb;
   import apmd_pkg::*;

   // Calibration constants of the meter
   localparam longint VOLT_GAIN = 12200;
   localparam longint VOLT_DIV  = 48977;
   localparam longint AMP_KNEE  = 1014;
   localparam longint LO_OFS    = 83;
   localparam longint LO_GAIN   = 1634000;
   localparam longint LO_DIV    = 2518955;
   localparam longint HI_OFS    = 62;
   localparam longint HI_GAIN   = 86000;
   localparam longint HI_DIV    = 135423;

   localparam int STALL_LIMIT    = 2000;   // cycles without any transfer
   localparam int ITEMS_PER_PASS = 100;
   localparam int PASSES         = 7;
   localparam int SETTLE_CYCLES  = 20;     // idle wait after the final drain

   typedef enum logic [1:0] {ROW_SAMPLE, ROW_KNOWN, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type  kind;
      csr_index_type reg_sel;
      logic [11:0]   reg_value;
      req_type       pair;
      rsp_type       known;
   } plan_row_type;

   typedef struct packed {
      sym_type hundreds;
      sym_type tens;
      sym_type ones;
   } readout_type;

   logic          clock        = 1'b0;
   logic          reset        = 1'b1;
   logic          req_valid    = 1'b0;
   logic          req_stall;
   req_type       req_data     = '0;
   logic          rsp_valid;
   logic          rsp_stall    = 1'b0;
   rsp_type       rsp_data;
   logic          csr_write_en = 1'b0;
   csr_index_type csr_index    = CSR_VOLT_LOW;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Meter model state
   logic [RAW_BITS-1:0]   volt_hist [WINDOW];
   logic [RAW_BITS-1:0]   amp_hist  [WINDOW];
   int unsigned           fill_slot;
   bit                    window_done;
   logic [TOTAL_BITS-1:0] volt_sum;
   logic [TOTAL_BITS-1:0] amp_sum;
   cfg_type               settings;

   rsp_type      pending_readings[$];
   plan_row_type plan[$];
   int           faults   = 0;
   int           readings = 0;
   int           idle_cycles = 0;
   bit           calm = 1'b0;

   averaging_panel_meter_display dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #4 clock = ~clock;

   // Three-digit split, clamped to 999, optional leading zero blanking
   function automatic readout_type spell_number(int unsigned n, bit blank_lead);
      readout_type d;
      if (n > 999) n = 999;
      d.hundreds = sym_type'(n / 100);
      d.tens     = sym_type'((n / 10) % 10);
      d.ones     = sym_type'(n % 10);
      if (d.hundreds == 4'd0 && blank_lead) begin
         d.hundreds = SYM_BLANK;
         if (d.tens == 4'd0) d.tens = SYM_BLANK;
      end
      return d;
   endfunction

   // Advance the window with one sample pair and format the reading
   function automatic rsp_type predict_reading(req_type item);
      rsp_type     r;
      readout_type d;
      longint      vmean;
      longint      amean;
      longint      volts;
      longint      amps;
      volt_sum = volt_sum - volt_hist[fill_slot] + item.volt_sample;
      amp_sum  = amp_sum - amp_hist[fill_slot] + item.amp_sample;
      volt_hist[fill_slot] = item.volt_sample;
      amp_hist[fill_slot]  = item.amp_sample;
      if (fill_slot == WINDOW - 1) begin
         fill_slot   = 0;
         window_done = 1'b1;
      end else begin
         fill_slot++;
      end
      vmean = volt_sum / WINDOW;
      amean = amp_sum / WINDOW;

      // calibration; current fit is piecewise and clamped at zero
      volts = vmean * VOLT_GAIN / VOLT_DIV;
      if (volts > 2047) volts = 2047;
      if (amean < AMP_KNEE) amps = (amean - LO_OFS) * LO_GAIN / LO_DIV;
      else amps = (amean - HI_OFS) * HI_GAIN / HI_DIV;
      if (amps < 0) amps = 0;
      if (amps > 4095) amps = 4095;

      r = '0;
      r.volts_scaled    = volts[VOLT_BITS-1:0];
      r.amps_scaled     = amps[AMP_BITS-1:0];
      r.volt_sym_first  = SYM_BLANK;
      r.volt_sym_second = SYM_BLANK;
      r.volt_sym_third  = SYM_BLANK;
      r.amp_sym_first   = SYM_BLANK;
      r.amp_sym_second  = SYM_BLANK;
      r.amp_sym_third   = SYM_BLANK;
      r.shown           = window_done;
      if (window_done) begin
         // voltage: Lo, oV, tenths without point, or hundredths with point
         if (volts < settings.volt_low_limit) begin
            r.volt_sym_second = SYM_L;
            r.volt_sym_third  = SYM_O;
         end else if (volts >= settings.volt_high_limit) begin
            r.volt_sym_second = SYM_O;
            r.volt_sym_third  = SYM_V;
         end else begin
            if (volts >= settings.volt_range_split) begin
               d = spell_number(int'(volts / 10), 1'b0);
            end else begin
               d = spell_number(int'(volts), 1'b0);
               r.volt_point = 1'b1;
            end
            r.volt_sym_first  = d.hundreds;
            r.volt_sym_second = d.tens;
            r.volt_sym_third  = d.ones;
         end
         // current: zero-suppressed below the split, tenths with point above
         if (amps < settings.amp_range_split) begin
            d = spell_number(int'(amps), 1'b1);
         end else begin
            d = spell_number(int'(amps / 10), 1'b0);
            r.amp_point = 1'b1;
         end
         r.amp_sym_first  = d.hundreds;
         r.amp_sym_second = d.tens;
         r.amp_sym_third  = d.ones;
      end
      return r;
   endfunction

   function automatic plan_row_type sample_row(logic [11:0] v, logic [11:0] a);
      plan_row_type r;
      r = '0;
      r.kind = ROW_SAMPLE;
      r.pair.volt_sample = v;
      r.pair.amp_sample  = a;
      return r;
   endfunction

   function automatic plan_row_type known_row(logic [11:0] v, logic [11:0] a, rsp_type want);
      plan_row_type r;
      r = sample_row(v, a);
      r.kind  = ROW_KNOWN;
      r.known = want;
      return r;
   endfunction

   function automatic plan_row_type csr_row(csr_index_type sel, logic [11:0] value);
      plan_row_type r;
      r = '0;
      r.kind      = ROW_CSR;
      r.reg_sel   = sel;
      r.reg_value = value;
      return r;
   endfunction

   // Level for a burst, weighted toward the display thresholds and extremes
   function automatic int unsigned pick_level();
      case ($urandom_range(5))
         0: return 0;
         1: return $urandom_range(150);
         2: return $urandom_range(1150, 900);
         3: return 4095;
         4: return $urandom_range(4095, 3800);
         default: return $urandom_range(4095);
      endcase
   endfunction

   function automatic logic [11:0] near(int unsigned level);
      int v;
      v = int'(level) + int'($urandom_range(30)) - 15;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[11:0];
   endfunction

   function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         faults++;
         if (faults <= 10)
            $display("reading %0d %s: expected %0d, got %0d", readings, field, want, got);
      end
   endfunction

   // One sample pair transfer; the expectation is queued once it is taken
   task automatic send_pair(req_type item, bit use_known, rsp_type known);
      rsp_type want;
      while (!calm && $urandom_range(99) < 15) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      want = predict_reading(item);
      pending_readings.push_back(use_known ? known : want);
   endtask

   // Hold off the sender until every reading has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type sel, logic [11:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= sel;
      csr_wdata    <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (sel)
         CSR_VOLT_LOW:   settings.volt_low_limit   = value[VOLT_BITS-1:0];
         CSR_VOLT_HIGH:  settings.volt_high_limit  = value[VOLT_BITS-1:0];
         CSR_VOLT_SPLIT: settings.volt_range_split = value[VOLT_BITS-1:0];
         CSR_AMP_SPLIT:  settings.amp_range_split  = value[AMP_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Result side: check each transfer, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         readings++;
         if (pending_readings.size() == 0) begin
            faults++;
            if (faults <= 10) $display("reading %0d: no reading expected", readings);
         end else begin
            rsp_type want;
            want = pending_readings.pop_front();
            compare_field("volts_scaled", want.volts_scaled, rsp_data.volts_scaled);
            compare_field("amps_scaled", want.amps_scaled, rsp_data.amps_scaled);
            compare_field("volt_sym_first", want.volt_sym_first, rsp_data.volt_sym_first);
            compare_field("volt_sym_second", want.volt_sym_second, rsp_data.volt_sym_second);
            compare_field("volt_sym_third", want.volt_sym_third, rsp_data.volt_sym_third);
            compare_field("volt_point", want.volt_point, rsp_data.volt_point);
            compare_field("amp_sym_first", want.amp_sym_first, rsp_data.amp_sym_first);
            compare_field("amp_sym_second", want.amp_sym_second, rsp_data.amp_sym_second);
            compare_field("amp_sym_third", want.amp_sym_third, rsp_data.amp_sym_third);
            compare_field("amp_point", want.amp_point, rsp_data.amp_point);
            compare_field("shown", want.shown, rsp_data.shown);
         end
      end
      rsp_stall <= !calm && ($urandom_range(99) < 15);
   end

   // Watchdog: no transfer on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("averaging_panel_meter_display: mismatch");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      cfg_type  pass_cfg;
      req_type  item;
      int       made;
      int       burst;
      int unsigned vlevel;
      int unsigned alevel;

      // model reset state
      foreach (volt_hist[i]) begin
         volt_hist[i] = '0;
         amp_hist[i]  = '0;
      end
      fill_slot   = 0;
      window_done = 1'b0;
      volt_sum    = '0;
      amp_sum     = '0;
      settings    = '{11'd300, 11'd2047, 11'd1000, 12'd1000};

      // Directed: first reading after reset (negative fit clamps to zero),
      // fill to a full window of low readings, then each display mode
      plan.push_back(known_row(12'd0, 12'd0, rsp_type'{11'd0, 12'd0,
         SYM_BLANK, SYM_BLANK, SYM_BLANK, 1'b0, SYM_BLANK, SYM_BLANK, SYM_BLANK, 1'b0, 1'b0}));
      for (int i = 1; i < WINDOW; i++) plan.push_back(sample_row(12'd1000, 12'd91));
      // whole window at 1000 / 91: Lo on voltage, current 5 zero-suppressed
      plan.push_back(known_row(12'd1000, 12'd91, rsp_type'{11'd249, 12'd5,
         SYM_BLANK, SYM_L, SYM_O, 1'b0, SYM_BLANK, SYM_BLANK, 4'd5, 1'b0, 1'b1}));
      plan.push_back(csr_row(CSR_VOLT_LOW, 12'd0));
      plan.push_back(sample_row(12'd1000, 12'd91));
      plan.push_back(csr_row(CSR_VOLT_SPLIT, 12'd0));
      plan.push_back(sample_row(12'd1000, 12'd91));
      plan.push_back(csr_row(CSR_VOLT_HIGH, 12'd249));
      plan.push_back(sample_row(12'd1000, 12'd91));
      plan.push_back(csr_row(CSR_AMP_SPLIT, 12'd0));
      plan.push_back(sample_row(12'd1000, 12'd91));
      plan.push_back(sample_row(12'd4095, 12'd4095));
      plan.push_back(sample_row(12'd4095, 12'd0));
      plan.push_back(sample_row(12'd0, 12'd4095));
      plan.push_back(sample_row(12'd4095, 12'd4095));

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            drain();
            write_csr(plan[i].reg_sel, plan[i].reg_value);
         end else begin
            send_pair(plan[i].pair, plan[i].kind == ROW_KNOWN, plan[i].known);
         end
      end

      // Random passes, each under its own register setting
      for (int pass = 0; pass < PASSES; pass++) begin
         case (pass)
            0: pass_cfg = '{11'd300, 11'd2047, 11'd1000, 12'd1000};
            1: pass_cfg = '{11'd0, 11'd2047, 11'd2047, 12'd4095};
            2: pass_cfg = '{11'd2047, 11'd2047, 11'd0, 12'd0};
            3: pass_cfg = '{11'd0, 11'd0, 11'd0, 12'd0};
            default: begin
               pass_cfg.volt_low_limit   = 11'($urandom_range(600));
               pass_cfg.volt_high_limit  = 11'($urandom_range(2047, 700));
               pass_cfg.volt_range_split = 11'($urandom_range(2047));
               pass_cfg.amp_range_split  = 12'($urandom_range(4095));
            end
         endcase
         drain();
         calm = (pass == 5);
         write_csr(CSR_VOLT_LOW, 12'(pass_cfg.volt_low_limit));
         write_csr(CSR_VOLT_HIGH, 12'(pass_cfg.volt_high_limit));
         write_csr(CSR_VOLT_SPLIT, 12'(pass_cfg.volt_range_split));
         write_csr(CSR_AMP_SPLIT, 12'(pass_cfg.amp_range_split));

         // bursts around a level; one in ten samples is pure noise
         made = 0;
         while (made < ITEMS_PER_PASS) begin
            vlevel = pick_level();
            alevel = pick_level();
            burst  = $urandom_range(40, 8);
            for (int k = 0; k < burst && made < ITEMS_PER_PASS; k++) begin
               if ($urandom_range(9) == 0) begin
                  item = req_type'(24'($urandom));
               end else begin
                  item.volt_sample = near(vlevel);
                  item.amp_sample  = near(alevel);
               end
               send_pair(item, 1'b0, '0);
               made++;
            end
         end
      end

      drain();
      calm = 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (faults == 0)
         $display("averaging_panel_meter_display: match");
      else
         $display("averaging_panel_meter_display: mismatch");
      $finish;
   end

endmodule
